// ===== rtl/dsmfd_pkg.sv =====
// Shared types and constants of the DSM serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package dsmfd_pkg;

    // Parser phases
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HUNT   = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DECODE = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE_A   = 3'd0;
    localparam logic [2:0] CFG_MODE_B   = 3'd1;
    localparam logic [2:0] CFG_MODE_C   = 3'd2;
    localparam logic [2:0] CFG_MODE_D   = 3'd3;
    localparam logic [2:0] CFG_THR_CHAN = 3'd4;

    // Configuration reset values
    localparam logic [7:0] MODE_A_RST   = 8'd1;
    localparam logic [7:0] MODE_B_RST   = 8'd18;
    localparam logic [7:0] MODE_C_RST   = 8'd162;
    localparam logic [7:0] MODE_D_RST   = 8'd178;
    localparam logic [3:0] THR_CHAN_RST = 4'd0;

    // Servo word fields
    localparam logic [15:0] CHAN_MASK  = 16'h7800;
    localparam logic [15:0] POS_MASK   = 16'h07FF;
    localparam int          CHAN_SHIFT = 11;

    // Scaling: value = base * pos + floor(pos * FRAC_MUL / DIV)
    localparam int POS_BASE     = 32;
    localparam int POS_FRAC_MUL = 1514;
    localparam int POS_DIV      = 100000;
    localparam int POS_RCP      = 167;      // floor(2^24 / POS_DIV)
    localparam int POS_RCP_SH   = 24;
    localparam int THR_OFFSET   = 205;
    localparam int THR_BASE     = 40;
    localparam int THR_FRAC_MUL = 91575;
    localparam int THR_DIV      = 10000000;
    localparam int THR_RCP      = 429;      // floor(2^32 / THR_DIV)
    localparam int THR_RCP_SH   = 32;

    // Configuration write
    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    // One parsed servo word, front to back
    typedef struct packed {
        logic [3:0]  channel;
        logic [10:0] position;
        logic        throttle;
        logic [7:0]  fades;
        logic [7:0]  mode;
        logic        last;
    } word_t;

    // Queue status
    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dsm_serial_frame_decoder_unit.sv =====
// Top level of the DSM serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the byte stream of a DSM satellite receiver. After reset the block
// hunts for a zero fades byte followed by one of four programmable mode codes,
// drops the rest of that frame, and then cuts the stream into frames of
// 2 + 2*SERVO_WORDS bytes. Every completed servo word gives one output word with
// channel, position, a 16-bit scaled value, the frame's fades and mode bytes,
// and tlast on the final word of a frame. One byte is taken every cycle while the
// queue is not full: the parser classifies each byte combinationally, and the
// scaler is a three-register pipeline (constant product, reciprocal quotient,
// correction and saturation) that takes a word every cycle while its output is
// not stalled. A servo word's low byte is pushed into the queue, and the word then
// passes the three scaler registers to the output. A two-entry queue separates
// parser and scaler; s_axis_tready drops only while that queue is full. Sync is
// never re-acquired after the first lock; only reset restarts the hunt.
// Configuration writes are always ready and take effect on the next cycle.
module dsm_serial_frame_decoder_unit #(
    parameter int SERVO_WORDS = 7
) (
    input  wire         clk,
    input  wire         rst_n,
    // rx_byte[7:0]
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,
    // channel[3:0], position[14:4], scaled_value[30:15], fades[38:31],
    // mode[46:39], zero[47]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);
    import dsmfd_pkg::*;

    cfg_wr_t     cfg_wr;
    logic        push, pop;
    word_t       push_word, head_word;
    queue_stat_t qstat;
    logic [3:0]  thr_chan;

    logic [3:0]  out_channel;
    logic [10:0] out_position;
    logic [15:0] out_scaled;
    logic [7:0]  out_fades, out_mode;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    dsmfd_front #(
        .SERVO_WORDS(SERVO_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_ready   (s_axis_tready),
        .queue_full (qstat.full),
        .push       (push),
        .push_word  (push_word),
        .thr_chan   (thr_chan)
    );

    dsmfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .stat      (qstat)
    );

    dsmfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (qstat.valid),
        .head_word    (head_word),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_channel  (out_channel),
        .out_position (out_position),
        .out_scaled   (out_scaled),
        .out_fades    (out_fades),
        .out_mode     (out_mode),
        .out_last     (m_axis_tlast)
    );

    // Pack the output word
    assign m_axis_tdata = {1'b0, out_mode, out_fades, out_scaled, out_position, out_channel};

    // Parser never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !qstat.full)
        else $error("word pushed into full queue");

    // Non-throttle scaling keeps position in the upper eleven bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_channel != thr_chan) |-> (out_scaled[15:5] == out_position))
        else $error("scaled value does not track position");

    // Throttle at or below the offset scales to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_channel == thr_chan && out_position <= 11'(THR_OFFSET))
        |-> (out_scaled == 16'd0))
        else $error("throttle below offset not zero");

endmodule

`default_nettype wire

// ===== rtl/dsmfd_front.sv =====
// Byte parser: sync hunt, frame counting and servo word extraction.
`timescale 1ns / 1ps
`default_nettype none

module dsmfd_front #(
    parameter int SERVO_WORDS = 7
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  dsmfd_pkg::cfg_wr_t    cfg_wr,
    input  wire                   in_valid,
    input  wire  [7:0]            in_byte,
    output logic                  in_ready,
    input  wire                   queue_full,
    output logic                  push,
    output dsmfd_pkg::word_t      push_word,
    output logic [3:0]            thr_chan
);
    import dsmfd_pkg::*;

    localparam int FRAME_BYTES = 2 + 2 * SERVO_WORDS;
    localparam int SKIP_BYTES  = 2 * SERVO_WORDS;
    localparam int CNT_W       = $clog2(FRAME_BYTES);

    logic [7:0] mode_a_reg, mode_b_reg, mode_c_reg, mode_d_reg;
    logic [3:0] thr_chan_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] prev_reg, prev_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] fades_reg, fades_next;
    logic [7:0] mode_reg, mode_next;

    logic        accept;
    logic        is_mode;
    logic [15:0] word;
    logic [3:0]  chan;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_a_reg   <= MODE_A_RST;
            mode_b_reg   <= MODE_B_RST;
            mode_c_reg   <= MODE_C_RST;
            mode_d_reg   <= MODE_D_RST;
            thr_chan_reg <= THR_CHAN_RST;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                CFG_MODE_A:   mode_a_reg   <= cfg_wr.data;
                CFG_MODE_B:   mode_b_reg   <= cfg_wr.data;
                CFG_MODE_C:   mode_c_reg   <= cfg_wr.data;
                CFG_MODE_D:   mode_d_reg   <= cfg_wr.data;
                CFG_THR_CHAN: thr_chan_reg <= cfg_wr.data[3:0];
                default:      ;
            endcase
        end
    end

    assign thr_chan = thr_chan_reg;
    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign is_mode  = (in_byte == mode_a_reg) || (in_byte == mode_b_reg) ||
                      (in_byte == mode_c_reg) || (in_byte == mode_d_reg);
    assign word     = {high_reg, in_byte};
    assign chan     = 4'((word & CHAN_MASK) >> CHAN_SHIFT);

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            prev_reg  <= '0;
            count_reg <= '0;
            high_reg  <= '0;
            fades_reg <= '0;
            mode_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            fades_reg <= fades_next;
            mode_reg  <= mode_next;
        end
    end

    // Classify each byte and emit completed servo words
    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        high_next  = high_reg;
        fades_next = fades_reg;
        mode_next  = mode_reg;
        push       = 1'b0;

        push_word.channel  = chan;
        push_word.position = 11'(word & POS_MASK);
        push_word.throttle = (chan == thr_chan_reg);
        push_word.fades    = fades_reg;
        push_word.mode     = mode_reg;
        push_word.last     = (count_reg == CNT_W'(FRAME_BYTES - 1));

        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    prev_next  = in_byte;
                    phase_next = PH_HUNT;
                end
                PH_HUNT:
                begin
                    if (prev_reg == 8'd0 && is_mode)
                    begin
                        fades_next = prev_reg;
                        mode_next  = in_byte;
                        count_next = '0;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        prev_next = in_byte;
                    end
                end
                PH_SKIP:
                begin
                    // Drop the rest of the sync frame
                    if (count_reg == CNT_W'(SKIP_BYTES - 1))
                    begin
                        count_next = '0;
                        phase_next = PH_DECODE;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                PH_DECODE:
                begin
                    if (count_reg == CNT_W'(FRAME_BYTES - 1))
                        count_next = '0;
                    else
                        count_next = count_reg + CNT_W'(1);

                    if (count_reg == CNT_W'(0))
                        fades_next = in_byte;
                    else if (count_reg == CNT_W'(1))
                        mode_next = in_byte;
                    else if (!count_reg[0])
                        high_next = in_byte;
                    else
                        push = 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsmfd_queue.sv =====
// Two-entry queue of parsed servo words between parser and scaler.
`timescale 1ns / 1ps
`default_nettype none

module dsmfd_queue (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    input  dsmfd_pkg::word_t          push_word,
    input  wire                       pop,
    output dsmfd_pkg::word_t          head_word,
    output dsmfd_pkg::queue_stat_t    stat
);
    import dsmfd_pkg::*;

    word_t      entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign head_word  = entry_reg[rd_ptr_reg];

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsmfd_back.sv =====
// Scaling pipeline: offset and fraction product, reciprocal quotient, correction and output.
`timescale 1ns / 1ps
`default_nettype none

module dsmfd_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    head_valid,
    input  dsmfd_pkg::word_t       head_word,
    output logic                   pop,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [3:0]             out_channel,
    output logic [10:0]            out_position,
    output logic [15:0]            out_scaled,
    output logic [7:0]             out_fades,
    output logic [7:0]             out_mode,
    output logic                   out_last
);
    import dsmfd_pkg::*;

    typedef struct packed {
        word_t       w;
        logic [16:0] base;
        logic [27:0] frac;
    } s1_t;

    typedef struct packed {
        word_t       w;
        logic [16:0] base;
        logic [27:0] frac;
        logic [4:0]  qe;
    } s2_t;

    logic advance;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    word_t       ow_reg;
    logic [15:0] scaled_reg, scaled_next;

    logic [10:0] diff;
    logic [36:0] prod;
    logic [27:0] qd;
    logic [27:0] rem;
    logic [5:0]  q;
    logic [17:0] sum;

    assign advance = !out_valid_reg || out_ready;
    assign pop     = head_valid && advance;

    // Stage 1: offset, integer part and fraction numerator
    always_comb
    begin
        diff          = head_word.position - 11'(THR_OFFSET);
        s1_next.w     = head_word;
        s1_next.base  = 17'(head_word.position) * 17'(POS_BASE);
        s1_next.frac  = 28'(head_word.position) * 28'(POS_FRAC_MUL);
        if (head_word.throttle)
        begin
            if (head_word.position <= 11'(THR_OFFSET))
            begin
                s1_next.base = '0;
                s1_next.frac = '0;
            end
            else
            begin
                s1_next.base = 17'(diff) * 17'(THR_BASE);
                s1_next.frac = 28'(diff) * 28'(THR_FRAC_MUL);
            end
        end
    end

    // Stage 2: quotient estimate by reciprocal, never above the true quotient
    always_comb
    begin
        if (s1_reg.w.throttle)
        begin
            prod       = 37'(s1_reg.frac) * 37'(THR_RCP);
            s2_next.qe = 5'(prod >> THR_RCP_SH);
        end
        else
        begin
            prod       = 37'(s1_reg.frac) * 37'(POS_RCP);
            s2_next.qe = 5'(prod >> POS_RCP_SH);
        end
        s2_next.w    = s1_reg.w;
        s2_next.base = s1_reg.base;
        s2_next.frac = s1_reg.frac;
    end

    // Stage 3: correct the estimate by one, add and saturate
    always_comb
    begin
        if (s2_reg.w.throttle)
        begin
            qd  = 28'(s2_reg.qe) * 28'(THR_DIV);
            rem = s2_reg.frac - qd;
            q   = 6'(s2_reg.qe) + 6'(rem >= 28'(THR_DIV));
        end
        else
        begin
            qd  = 28'(s2_reg.qe) * 28'(POS_DIV);
            rem = s2_reg.frac - qd;
            q   = 6'(s2_reg.qe) + 6'(rem >= 28'(POS_DIV));
        end
        sum = 18'(s2_reg.base) + 18'(q);
        if (sum > 18'hFFFF)
            scaled_next = 16'hFFFF;
        else
            scaled_next = sum[15:0];
    end

    // Valid bits move together, holding while the output word waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            ow_reg     <= s2_reg.w;
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = ow_reg.channel;
    assign out_position = ow_reg.position;
    assign out_scaled   = scaled_reg;
    assign out_fades    = ow_reg.fades;
    assign out_mode     = ow_reg.mode;
    assign out_last     = ow_reg.last;

endmodule

`default_nettype wire

// ===== tb/tb_dsm_serial_frame_decoder_unit.sv =====
// Self-checking testbench for the DSM serial frame decoder top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_dsm_serial_frame_decoder_unit;
    import dsmfd_pkg::*;

    localparam int SERVO_WORDS      = 7;
    localparam int FRAME_BYTES      = 2 + 2 * SERVO_WORDS;
    localparam int SYNC_SKIP_BYTES  = 2 * SERVO_WORDS;
    localparam int IDLE_PCT         = 23;
    localparam int RAND_PHASES      = 5;
    localparam int FRAMES_PER_PHASE = 12;
    localparam int DRAIN_CYCLES     = 12;
    localparam int STALL_LIMIT      = 2000;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Scaling constants as exact decimal ratios
    localparam longint unsigned STD_NUM = 64'd3201514;
    localparam longint unsigned STD_DEN = 64'd100000;
    localparam longint unsigned THR_NUM = 64'd400091575;
    localparam longint unsigned THR_DEN = 64'd10000000;
    localparam longint unsigned THR_OFS = 64'd205;

    // One decoded servo word as seen on the output stream
    typedef struct packed {
        logic [3:0]  channel;
        logic [10:0] position;
        logic [15:0] scaled;
        logic [7:0]  fades;
        logic [7:0]  mode;
        logic        last;
    } servo_word_t;

    // One row of the directed byte table
    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        servo_word_t want;
    } byte_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [7:0]  cfg_data      = '0;

    // Shadow copy of the block's registers and parser state
    logic [7:0]  mode_codes [4];
    logic [3:0]  thr_chan;
    phase_t      prs_phase;
    logic [7:0]  prs_prev;
    int unsigned prs_count;
    logic [7:0]  prs_high;
    logic [7:0]  prs_fades;
    logic [7:0]  prs_mode;

    servo_word_t pending_words [$];
    byte_row_t   directed_rows [$];

    bit steady_run   = 1'b0;
    int errors       = 0;
    int bytes_fed    = 0;
    int words_seen   = 0;
    int thr_words    = 0;
    int sat_words    = 0;
    int cfg_writes   = 0;
    int stall_cycles = 0;

    dsm_serial_frame_decoder_unit #(
        .SERVO_WORDS(SERVO_WORDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Scale a position, with the throttle offset on the throttle channel
    function automatic logic [15:0] scale_pos(input logic [3:0] ch, input logic [10:0] pos);
        longint unsigned v;
        v = 64'(pos);
        if (ch == thr_chan)
        begin
            if (v <= THR_OFS)
                return 16'd0;
            v = ((v - THR_OFS) * THR_NUM) / THR_DEN;
        end
        else
        begin
            v = (v * STD_NUM) / STD_DEN;
        end
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Advance the shadow parser by one byte; got is set when a servo word completes
    task automatic decode_rx_byte(input logic [7:0] b, output logic got, output servo_word_t w);
        logic [15:0] word;
        int unsigned idx;
        got = 1'b0;
        w   = '0;
        case (prs_phase)
            PH_WAIT:
            begin
                prs_prev  = b;
                prs_phase = PH_HUNT;
            end
            PH_HUNT:
            begin
                if (prs_prev == 8'd0 && (b == mode_codes[0] || b == mode_codes[1] ||
                                         b == mode_codes[2] || b == mode_codes[3]))
                begin
                    prs_fades = prs_prev;
                    prs_mode  = b;
                    prs_count = 0;
                    prs_phase = PH_SKIP;
                end
                else
                begin
                    prs_prev = b;
                end
            end
            PH_SKIP:
            begin
                prs_count++;
                if (prs_count >= SYNC_SKIP_BYTES)
                begin
                    prs_count = 0;
                    prs_phase = PH_DECODE;
                end
            end
            default:
            begin
                idx       = prs_count;
                prs_count = (idx + 1 >= FRAME_BYTES) ? 0 : idx + 1;
                if (idx == 0)
                    prs_fades = b;
                else if (idx == 1)
                    prs_mode = b;
                else if (idx[0] == 1'b0)
                    prs_high = b;
                else
                begin
                    word       = {prs_high, b};
                    w.channel  = word[14:11];
                    w.position = word[10:0];
                    w.scaled   = scale_pos(w.channel, w.position);
                    w.fades    = prs_fades;
                    w.mode     = prs_mode;
                    w.last     = (idx + 1 >= FRAME_BYTES);
                    got        = 1'b1;
                end
            end
        endcase
    endtask

    // Offer one byte, hold it until taken, then log the word it completes
    task automatic feed(input logic [7:0] b, input logic typed, input servo_word_t want);
        logic        got;
        servo_word_t w;
        @(negedge clk);
        while (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_fed++;
        decode_rx_byte(b, got, w);
        if (got)
        begin
            if (typed)
                w = want;
            pending_words.push_back(w);
            if (w.channel == thr_chan)
                thr_words++;
            if (w.scaled == 16'hFFFF)
                sat_words++;
        end
    endtask

    // Write one configuration register and mirror it
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODE_A:   mode_codes[0] = val;
            CFG_MODE_B:   mode_codes[1] = val;
            CFG_MODE_C:   mode_codes[2] = val;
            CFG_MODE_D:   mode_codes[3] = val;
            CFG_THR_CHAN: thr_chan      = val[3:0];
            default:      ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop the input, wait for every expected word, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic plain_row(input logic [7:0] rx);
        byte_row_t r;
        r    = '0;
        r.rx = rx;
        directed_rows.push_back(r);
    endtask

    task automatic typed_row(input logic [7:0] rx, input logic [3:0] ch, input logic [10:0] pos,
                             input logic [15:0] sc, input logic [7:0] fd, input logic [7:0] md,
                             input logic last);
        byte_row_t r;
        r.rx            = rx;
        r.typed         = 1'b1;
        r.want.channel  = ch;
        r.want.position = pos;
        r.want.scaled   = sc;
        r.want.fades    = fd;
        r.want.mode     = md;
        r.want.last     = last;
        directed_rows.push_back(r);
    endtask

    // One frame of servo words biased toward the throttle channel and the edges
    task automatic send_random_frame();
        logic [3:0]  ch;
        logic [10:0] pos;
        logic        hi_bit;
        logic        noisy;
        noisy = ($urandom_range(7) == 0);
        feed(8'($urandom_range(255)), 1'b0, '0);
        feed(8'($urandom_range(255)), 1'b0, '0);
        for (int k = 0; k < SERVO_WORDS; k++)
        begin
            if (noisy)
            begin
                feed(8'($urandom_range(255)), 1'b0, '0);
                feed(8'($urandom_range(255)), 1'b0, '0);
            end
            else
            begin
                ch     = ($urandom_range(99) < 35) ? thr_chan : 4'($urandom_range(15));
                hi_bit = 1'($urandom_range(1));
                case ($urandom_range(5))
                    0:       pos = 11'($urandom_range(215, 195));
                    1:       pos = $urandom_range(1) ? 11'h7FF : 11'h000;
                    default: pos = 11'($urandom_range(2047));
                endcase
                feed({hi_bit, ch, pos[10:8]}, 1'b0, '0);
                feed(pos[7:0], 1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Receiver stalls at random except during the steady stretch
    always @(negedge clk)
        m_axis_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);

    // Compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        servo_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected output word: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                words_seen++;
                check_field("channel",      16'(exp_w.channel),  16'(m_axis_tdata[3:0]));
                check_field("position",     16'(exp_w.position), 16'(m_axis_tdata[14:4]));
                check_field("scaled_value", exp_w.scaled,        m_axis_tdata[30:15]);
                check_field("fades",        16'(exp_w.fades),    16'(m_axis_tdata[38:31]));
                check_field("mode",         16'(exp_w.mode),     16'(m_axis_tdata[46:39]));
                check_field("pad",          16'd0,               16'(m_axis_tdata[47]));
                check_field("last",         16'(exp_w.last),     16'(m_axis_tlast));
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
                     STALL_LIMIT, pending_words.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        // Shadow state after reset
        mode_codes[0] = MODE_A_RST;
        mode_codes[1] = MODE_B_RST;
        mode_codes[2] = MODE_C_RST;
        mode_codes[3] = MODE_D_RST;
        thr_chan      = THR_CHAN_RST;
        prs_phase     = PH_WAIT;
        prs_prev      = '0;
        prs_count     = 0;
        prs_high      = '0;
        prs_fades     = '0;
        prs_mode      = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hunt setup: 0xFF and 0x00 as mode codes, spare index must not add 0x07
        write_reg(CFG_MODE_A, 8'hFF);
        write_reg(CFG_MODE_B, 8'h12);
        write_reg(CFG_MODE_C, 8'h00);
        write_reg(CFG_MODE_D, 8'h81);
        write_reg(CFG_THR_CHAN, 8'd0);
        write_reg(CFG_SPARE_LO, 8'h07);

        // Hunt: first byte, zero then non-code, code after nonzero, then a lock on 0x81
        plain_row(8'h00);
        plain_row(8'h07);
        plain_row(8'hFF);
        plain_row(8'h00);
        plain_row(8'h81);
        // Rest of the sync frame is dropped
        for (int k = 0; k < SYNC_SKIP_BYTES; k++)
            plain_row(8'($urandom_range(255)));
        // First decoded frame: extreme fades and mode, edge positions
        plain_row(8'hFF);
        plain_row(8'h00);
        plain_row(8'h00);
        typed_row(8'h00, 4'd0,  11'd0,    16'd0,     8'hFF, 8'h00, 1'b0);
        plain_row(8'h00);
        typed_row(8'hCD, 4'd0,  11'd205,  16'd0,     8'hFF, 8'h00, 1'b0);
        plain_row(8'h00);
        typed_row(8'hCE, 4'd0,  11'd206,  16'd40,    8'hFF, 8'h00, 1'b0);
        plain_row(8'h87);   // bit 15 set, throttle saturates
        typed_row(8'hFF, 4'd0,  11'd2047, 16'd65535, 8'hFF, 8'h00, 1'b0);
        plain_row(8'h7F);
        typed_row(8'hFF, 4'd15, 11'd2047, 16'd65534, 8'hFF, 8'h00, 1'b0);
        plain_row(8'h08);
        typed_row(8'h01, 4'd1,  11'd1,    16'd32,    8'hFF, 8'h00, 1'b0);
        plain_row(8'hBC);   // bit 15 set, channel 7
        typed_row(8'h00, 4'd7,  11'd1024, 16'd32783, 8'hFF, 8'h00, 1'b1);

        foreach (directed_rows[i])
            feed(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        settle();

        // Random frames under changing throttle channel and rewritten mode codes
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_reg(CFG_THR_CHAN, (p == 0) ? 8'd15 : (p == 1) ? 8'd0 : 8'($urandom_range(15)));
            write_reg(CFG_MODE_A, 8'($urandom_range(255)));
            write_reg(CFG_MODE_B, 8'($urandom_range(255)));
            write_reg(CFG_MODE_C, 8'($urandom_range(255)));
            write_reg(CFG_MODE_D, 8'($urandom_range(255)));
            write_reg(3'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), 8'($urandom_range(255)));
            steady_run = (p == 2);
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
                send_random_frame();
            settle();
            steady_run = 1'b0;
        end

        $display("Fed %0d bytes (sync hunt, %0d frame phases) with %0d register writes.",
                 bytes_fed, RAND_PHASES + 1, cfg_writes);
        $display("Checked %0d servo words: %0d on the throttle channel, %0d saturated.",
                 words_seen, thr_words, sat_words);
        if (errors == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/dsmfd_pkg.sv
rtl/dsmfd_front.sv
rtl/dsmfd_queue.sv
rtl/dsmfd_back.sv
rtl/dsm_serial_frame_decoder_unit.sv
tb/tb_dsm_serial_frame_decoder_unit.sv
